// ===== hdl/sspq_pkg.sv =====
// Package with shared types, sizes and status codes for the sorted priority queue.
package sspq_pkg;

    // Number of cells in the sorted row.
    localparam int DEPTH = 128;
    // Fill count wide enough to hold DEPTH itself.
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Operation codes of a request.
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // One stored pair.
    typedef struct packed {
        logic signed [31:0] value;
        logic [7:0]         prio;
    } t_entry;

    // Command broadcast to every cell in a cycle.
    typedef struct packed {
        logic   ins;
        logic   rem;
        t_entry item;
    } t_cmd;

endpackage

// ===== hdl/sspq_cell.sv =====
// One cell of the sorted row: holds an entry and shifts with its neighbors.
module sspq_cell import sspq_pkg::*; (
    input  logic   i_clk,
    input  t_cmd   i_cmd,
    input  logic   i_valid,
    input  logic   i_left_valid,
    input  logic   i_left_gt,
    input  t_entry i_left_entry,
    input  t_entry i_right_entry,
    output t_entry o_entry,
    output logic   o_gt
);

    t_entry r_entry;
    t_entry n_entry;

    // This cell holds a priority strictly above the one being inserted.
    assign o_gt    = i_valid && (r_entry.prio > i_cmd.item.prio);
    assign o_entry = r_entry;

    // Insert shifts greater entries down one place and drops the new pair in
    // the first slot that is greater or empty; remove shifts everything up.
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins) begin
            if (i_left_gt) begin
                n_entry = i_left_entry;
            end else if (o_gt || (!i_valid && i_left_valid)) begin
                n_entry = i_cmd.item;
            end
        end else if (i_cmd.rem) begin
            n_entry = i_right_entry;
        end
    end

    // Entry storage needs no reset; the fill count tells which cells are live.
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ===== hdl/stable_sorted_priority_queue.sv =====
// Top level of the stable sorted priority queue built as a row of shifting cells.
// Usage:
//   A request is taken at each rising edge where start is high and busy is low.
//   i_op selects insert or remove of the head; i_in_value and i_in_priority
//   carry the pair to insert. busy stays low, so one request can be issued in
//   every cycle.
//   Each request produces one result in the next cycle: o_strobe is high for that
//   single cycle with o_status, o_out_value, o_out_priority and o_occupancy.
//   Throughput is one request per cycle, set by the cell row which shifts all
//   entries in parallel.
//   Equal priorities leave in arrival order. An insert into a full queue is
//   dropped with status full; a remove from an empty queue returns status
//   empty with zero value and priority.
//   Reset (synchronous, active low) empties the queue and clears the strobe;
//   cell contents are left as they are and are ignored until written.
//   The receiver cannot stall: a result must be taken in its strobe cycle.
module stable_sorted_priority_queue import sspq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_op,
    input  logic signed [31:0] i_in_value,
    input  logic [7:0]         i_in_priority,
    output logic               o_strobe,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_out_value,
    output logic [7:0]         o_out_priority,
    output logic [7:0]         o_occupancy
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_strobe;
    t_status          r_status;
    t_status          n_status;
    logic signed [31:0] r_out_value;
    logic signed [31:0] n_out_value;
    logic [7:0]       r_out_prio;
    logic [7:0]       n_out_prio;

    logic             full;
    logic             empty;
    t_cmd             cmd;
    logic [DEPTH-1:0] cell_valid;
    logic [DEPTH-1:0] cell_gt;
    t_entry           cell_entry [DEPTH];

    assign busy  = 1'b0;
    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);

    // Command sent to the row for an accepted request.
    always_comb begin
        cmd.ins        = start && (t_op'(i_op) == OP_INSERT) && !full;
        cmd.rem        = start && (t_op'(i_op) == OP_REMOVE) && !empty;
        cmd.item.value = i_in_value;
        cmd.item.prio  = i_in_priority;
    end

    // Live cells form a prefix of the row given by the fill count.
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            assign cell_valid[gi] = (CNT_W'(gi) < r_count);

            if (gi == 0) begin : g_head
                sspq_cell u_cell (
                    .i_clk         (i_clk),
                    .i_cmd         (cmd),
                    .i_valid       (cell_valid[gi]),
                    .i_left_valid  (1'b1),
                    .i_left_gt     (1'b0),
                    .i_left_entry  (cmd.item),
                    .i_right_entry (cell_entry[gi+1]),
                    .o_entry       (cell_entry[gi]),
                    .o_gt          (cell_gt[gi])
                );
            end else if (gi == DEPTH - 1) begin : g_tail
                sspq_cell u_cell (
                    .i_clk         (i_clk),
                    .i_cmd         (cmd),
                    .i_valid       (cell_valid[gi]),
                    .i_left_valid  (cell_valid[gi-1]),
                    .i_left_gt     (cell_gt[gi-1]),
                    .i_left_entry  (cell_entry[gi-1]),
                    .i_right_entry (cmd.item),
                    .o_entry       (cell_entry[gi]),
                    .o_gt          (cell_gt[gi])
                );
            end else begin : g_mid
                sspq_cell u_cell (
                    .i_clk         (i_clk),
                    .i_cmd         (cmd),
                    .i_valid       (cell_valid[gi]),
                    .i_left_valid  (cell_valid[gi-1]),
                    .i_left_gt     (cell_gt[gi-1]),
                    .i_left_entry  (cell_entry[gi-1]),
                    .i_right_entry (cell_entry[gi+1]),
                    .o_entry       (cell_entry[gi]),
                    .o_gt          (cell_gt[gi])
                );
            end
        end
    endgenerate

    // Fill count and result fields for the current request.
    always_comb begin
        n_count     = r_count;
        n_status    = ST_OK;
        n_out_value = '0;
        n_out_prio  = '0;
        if (cmd.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (cmd.rem) begin
            n_count     = r_count - CNT_W'(1);
            n_out_value = cell_entry[0].value;
            n_out_prio  = cell_entry[0].prio;
        end else if (start && (t_op'(i_op) == OP_INSERT)) begin
            n_status = ST_FULL;
        end else if (start) begin
            n_status = ST_EMPTY;
        end
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= start;
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_out_value <= n_out_value;
        r_out_prio  <= n_out_prio;
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_out_value    = r_out_value;
    assign o_out_priority = r_out_prio;
    assign o_occupancy    = 8'(r_count);

endmodule
